/* sv/u16u8_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 encoder.
`default_nettype none
package u16u8_pkg;

	localparam logic [15:0] SURR_MASK   = 16'hF800;
	localparam logic [15:0] SURR_BASE   = 16'hD800;
	localparam logic [15:0] SURR_LOWBIT = 16'h0400;
	localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
	localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;
	localparam logic [20:0] PLANE_BASE  = 21'h010000;
	localparam logic [7:0]  CONT_MARK   = 8'h80;
	localparam logic [7:0]  LEAD2_MARK  = 8'hC0;
	localparam logic [7:0]  LEAD3_MARK  = 8'hE0;
	localparam logic [7:0]  LEAD4_MARK  = 8'hF0;

	typedef struct packed {
		logic [9:0] high_bits;
		logic       pend;
		logic       ended;
	} enc_state_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
	} enc_run_t;

endpackage
`default_nettype wire

/* sv/u16u8_ifs.sv */
// Valid/ready channel interfaces for code units in and UTF-8 bytes out.
`default_nettype none
interface u16u8_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        final_unit;

	modport source (output valid, output code_unit, output final_unit, input ready);
	modport sink (input valid, input code_unit, input final_unit, output ready);
endinterface

interface u16u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

/* sv/u16u8_enc.sv */
// Combinational encoder: one code unit plus surrogate state to a byte run.
`default_nettype none
module u16u8_enc (
	input  logic [15:0]           unit,
	input  logic                  fin,
	input  u16u8_pkg::enc_state_t st,
	output u16u8_pkg::enc_state_t st_nxt,
	output u16u8_pkg::enc_run_t   run
);
	import u16u8_pkg::*;

	logic [20:0] cp;

	assign cp = PLANE_BASE + {1'b0, st.high_bits, unit[9:0]};

	always_comb begin
		run = '0;
		st_nxt = st;
		if (!st.ended) begin
			if (unit == 16'h0000) begin
				st_nxt.pend = 1'b0;
				st_nxt.high_bits = '0;
				st_nxt.ended = 1'b1;
			end else if ((unit & SURR_MASK) == SURR_BASE) begin
				if ((unit & SURR_LOWBIT) != 16'h0000) begin
					if (st.pend) begin
						run.bytes[0] = LEAD4_MARK | {5'b0, cp[20:18]};
						run.bytes[1] = CONT_MARK | {2'b0, cp[17:12]};
						run.bytes[2] = CONT_MARK | {2'b0, cp[11:6]};
						run.bytes[3] = CONT_MARK | {2'b0, cp[5:0]};
						run.n = 3'd4;
					end
					st_nxt.pend = 1'b0;
					st_nxt.high_bits = '0;
				end else begin
					st_nxt.pend = 1'b1;
					st_nxt.high_bits = unit[9:0];
				end
			end else begin
				st_nxt.pend = 1'b0;
				st_nxt.high_bits = '0;
				if (unit < ONE_BYTE_LIM) begin
					run.bytes[0] = unit[7:0];
					run.n = 3'd1;
				end else if (unit < TWO_BYTE_LIM) begin
					run.bytes[0] = LEAD2_MARK | {3'b0, unit[10:6]};
					run.bytes[1] = CONT_MARK | {2'b0, unit[5:0]};
					run.n = 3'd2;
				end else begin
					run.bytes[0] = LEAD3_MARK | {4'b0, unit[15:12]};
					run.bytes[1] = CONT_MARK | {2'b0, unit[11:6]};
					run.bytes[2] = CONT_MARK | {2'b0, unit[5:0]};
					run.n = 3'd3;
				end
			end
		end
		if (fin) begin
			st_nxt = '0;
		end
	end

endmodule
`default_nettype wire

/* sv/utf16_to_utf8_encoder_top.sv */
// Top level of the UTF-16 to UTF-8 encoder: input register, encoder, byte buffer.
//
//  channel  dir  payload                      item
//  in_ch    in   code_unit[15:0], final_unit  one UTF-16 code unit
//  out_ch   out  out_byte[7:0], run_last      one UTF-8 byte
//
// Each byte leaves in its own cycle, one byte per cycle while out_ch.ready is high;
// a run holds one to four bytes, and an item that yields no bytes does not use the buffer.
// The item is held in the input register and encoded, and its first byte is offered once the buffer is free.
// Reset clears the surrogate state and all valid flags.
// A stalled output holds the run; the input register keeps taking items
// until it holds one that needs the buffer.
`default_nettype none
module utf16_to_utf8_encoder_top (
	input  logic         clk,
	input  logic         arst_n,
	u16u8_in_if.sink     in_ch,
	u16u8_out_if.source  out_ch
);
	import u16u8_pkg::*;

	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        fin_s1;

	enc_state_t  st_q;
	enc_state_t  st_nxt;
	enc_run_t    run;

	logic            buf_vld_q;
	logic [3:0][7:0] bytes_q;
	logic [1:0]      last_q;
	logic [1:0]      idx_q;
	logic [2:0]      n_m1;

	logic buf_free;
	logic s1_adv;
	logic out_take;
	logic load_buf;

	u16u8_enc u_enc (
		.unit   (unit_s1),
		.fin    (fin_s1),
		.st     (st_q),
		.st_nxt (st_nxt),
		.run    (run)
	);

	assign out_take = out_ch.valid && out_ch.ready;
	assign buf_free = !buf_vld_q || (out_take && (idx_q == last_q));
	assign s1_adv = valid_s1 && ((run.n == 3'd0) || buf_free);
	assign load_buf = s1_adv && (run.n != 3'd0);
	assign n_m1 = run.n - 3'd1;
	assign in_ch.ready = !valid_s1 || s1_adv;

	assign out_ch.valid = buf_vld_q;
	assign out_ch.out_byte = bytes_q[idx_q];
	assign out_ch.run_last = (idx_q == last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= '0;
			buf_vld_q <= 1'b0;
			idx_q <= '0;
			last_q <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (s1_adv) begin
				st_q <= st_nxt;
			end
			if (load_buf) begin
				buf_vld_q <= 1'b1;
				idx_q <= '0;
				last_q <= n_m1[1:0];
			end else if (out_take) begin
				if (idx_q == last_q) begin
					buf_vld_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			unit_s1 <= in_ch.code_unit;
			fin_s1 <= in_ch.final_unit;
		end
		if (load_buf) begin
			bytes_q <= run.bytes;
		end
	end

	// a held high surrogate never coexists with an ended string
	a_pend_vs_ended: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.pend && st_q.ended))
		else $error("pending surrogate while string ended");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		buf_vld_q |-> (idx_q <= last_q))
		else $error("byte index past end of run");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(unit_s1) && $stable(fin_s1)))
		else $error("stalled input register changed");

	a_run_not_cut: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_vld_q && !(out_take && (idx_q == last_q))) |=> (buf_vld_q && $stable(bytes_q)))
		else $error("byte run overwritten before drained");

endmodule
`default_nettype wire

/* dv/tb_utf16_to_utf8_encoder_top.sv */
// Self-checking testbench for utf16_to_utf8_encoder_top: code units in, predicted UTF-8 bytes checked.
module tb_utf16_to_utf8_encoder_top;
	import u16u8_pkg::*;

	typedef struct packed {
		logic [15:0] unit;
		logic        fin;
	} unit_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} utf8_byte_t;

	typedef enum int {CH_ASCII, CH_TWO, CH_THREE, CH_PAIR} char_kind_t;
	typedef enum int {STR_CLEAN, STR_NOISE, STR_BROKEN, STR_TERMINATED} str_kind_t;

	logic clk;
	logic arst_n;

	u16u8_in_if  in_if ();
	u16u8_out_if out_if ();

	utf16_to_utf8_encoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	unit_item_t unit_q[$];
	utf8_byte_t utf8_q[$];

	logic [9:0] held_high;
	logic       high_held;
	logic       str_done;

	int  err_count;
	int  units_in;
	int  bytes_out;
	int  four_byte_chars;
	int  strings_sent;
	int  rand_units;
	bit  in_fire;
	bit  hold_off;

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH t=%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic push_char(input logic [20:0] cp);
		logic [7:0] seq [4];
		int         n;
		if (cp < {5'b0, ONE_BYTE_LIM}) begin
			seq[0] = cp[7:0];
			n = 1;
		end else if (cp < {5'b0, TWO_BYTE_LIM}) begin
			seq[0] = LEAD2_MARK | {3'b0, cp[10:6]};
			seq[1] = CONT_MARK | {2'b0, cp[5:0]};
			n = 2;
		end else if (cp < PLANE_BASE) begin
			seq[0] = LEAD3_MARK | {4'b0, cp[15:12]};
			seq[1] = CONT_MARK | {2'b0, cp[11:6]};
			seq[2] = CONT_MARK | {2'b0, cp[5:0]};
			n = 3;
		end else begin
			seq[0] = LEAD4_MARK | {5'b0, cp[20:18]};
			seq[1] = CONT_MARK | {2'b0, cp[17:12]};
			seq[2] = CONT_MARK | {2'b0, cp[11:6]};
			seq[3] = CONT_MARK | {2'b0, cp[5:0]};
			n = 4;
			four_byte_chars++;
		end
		for (int k = 0; k < n; k++)
			utf8_q.push_back('{data: seq[k], last: (k == n - 1)});
	endtask

	// Expected bytes for one accepted code unit; updates the surrogate/end state.
	task automatic encode_unit(input logic [15:0] unit, input logic fin);
		if (!str_done) begin
			if (unit == 16'h0000) begin
				high_held = 1'b0;
				held_high = '0;
				str_done  = 1'b1;
			end else if ((unit & SURR_MASK) == SURR_BASE) begin
				if ((unit & SURR_LOWBIT) != 16'h0000) begin
					if (high_held)
						push_char(PLANE_BASE + {1'b0, held_high, unit[9:0]});
					high_held = 1'b0;
					held_high = '0;
				end else begin
					held_high = unit[9:0];
					high_held = 1'b1;
				end
			end else begin
				high_held = 1'b0;
				held_high = '0;
				push_char({5'b0, unit});
			end
		end
		if (fin) begin
			held_high = '0;
			high_held = 1'b0;
			str_done  = 1'b0;
		end
	endtask

	function automatic void add_unit(input logic [15:0] unit, input logic fin, input bit counted);
		unit_q.push_back('{unit: unit, fin: fin});
		if (counted)
			rand_units++;
	endfunction

	function automatic void add_char(input char_kind_t kind);
		case (kind)
			CH_ASCII: add_unit(16'($urandom_range(1, 16'h7F)), 1'b0, 1'b1);
			CH_TWO: add_unit(16'($urandom_range(16'h80, 16'h7FF)), 1'b0, 1'b1);
			CH_THREE: begin
				if ($urandom_range(0, 1))
					add_unit(16'($urandom_range(16'h800, 16'hD7FF)), 1'b0, 1'b1);
				else
					add_unit(16'($urandom_range(16'hE000, 16'hFFFF)), 1'b0, 1'b1);
			end
			default: begin
				add_unit(16'hD800 | 16'($urandom_range(0, 1023)), 1'b0, 1'b1);
				add_unit(16'hDC00 | 16'($urandom_range(0, 1023)), 1'b0, 1'b1);
			end
		endcase
	endfunction

	function automatic void mark_final();
		unit_q[unit_q.size() - 1].fin = 1'b1;
	endfunction

	// Directed part: byte-length boundaries, surrogate pairing corners, string end and clear.
	function automatic void load_directed();
		add_unit(16'h0041, 1'b0, 1'b0);
		add_unit(16'h007F, 1'b0, 1'b0);
		add_unit(16'h0080, 1'b0, 1'b0);
		add_unit(16'h07FF, 1'b0, 1'b0);
		add_unit(16'h0800, 1'b0, 1'b0);
		add_unit(16'hD7FF, 1'b0, 1'b0);
		add_unit(16'hE000, 1'b0, 1'b0);
		add_unit(16'hFFFF, 1'b0, 1'b0);
		add_unit(16'hD800, 1'b0, 1'b0);
		add_unit(16'hDC00, 1'b0, 1'b0);
		add_unit(16'hDBFF, 1'b0, 1'b0);
		add_unit(16'hDFFF, 1'b0, 1'b0);
		add_unit(16'hDC00, 1'b0, 1'b0);
		add_unit(16'hD800, 1'b0, 1'b0);
		add_unit(16'hDA00, 1'b0, 1'b0);
		add_unit(16'hDC01, 1'b0, 1'b0);
		add_unit(16'hD811, 1'b0, 1'b0);
		add_unit(16'h0024, 1'b0, 1'b0);
		add_unit(16'hD900, 1'b0, 1'b0);
		add_unit(16'h0000, 1'b0, 1'b0);
		add_unit(16'h00E9, 1'b0, 1'b0);
		add_unit(16'hD800, 1'b0, 1'b0);
		add_unit(16'h4E2D, 1'b1, 1'b0);
		add_unit(16'hDBC0, 1'b1, 1'b0);
		add_unit(16'hDC00, 1'b1, 1'b0);
		add_unit(16'h0000, 1'b1, 1'b0);
	endfunction

	function automatic void load_random();
		str_kind_t skind;
		int        len;
		int        r;
		while (rand_units < 500) begin
			r   = $urandom_range(0, 9);
			len = $urandom_range(1, 12);
			skind = (r < 7) ? STR_CLEAN : (r == 7) ? STR_NOISE :
				(r == 8) ? STR_BROKEN : STR_TERMINATED;
			for (int i = 0; i < len; i++) begin
				case (skind)
					STR_NOISE: add_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b1);
					STR_BROKEN: begin
						case ($urandom_range(0, 2))
							0: add_unit(16'hD800 | 16'($urandom_range(0, 1023)), 1'b0, 1'b1);
							1: add_unit(16'hDC00 | 16'($urandom_range(0, 1023)), 1'b0, 1'b1);
							default: add_char(CH_ASCII);
						endcase
					end
					default: add_char(char_kind_t'($urandom_range(0, 3)));
				endcase
			end
			if (skind == STR_TERMINATED) begin
				add_unit(16'h0000, 1'b0, 1'b1);
				repeat ($urandom_range(1, 3))
					add_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b0);
				mark_final();
			end else if ($urandom_range(0, 4) != 0) begin
				mark_final();
			end
			strings_sent++;
		end
	endfunction

	initial begin
		arst_n           = 1'b0;
		in_if.valid      = 1'b0;
		in_if.code_unit  = '0;
		in_if.final_unit = 1'b0;
		out_if.ready     = 1'b0;
		held_high        = '0;
		high_held        = 1'b0;
		str_done         = 1'b0;
		hold_off         = 1'b0;
		load_directed();
		load_random();
	end

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else if (!in_if.valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				in_if.valid <= 1'b0;
			end else if (unit_q.size() != 0) begin
				in_if.code_unit  <= unit_q[0].unit;
				in_if.final_unit <= unit_q[0].fin;
				in_if.valid      <= 1'b1;
				void'(unit_q.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern steps through always ready, half random, mostly stalled and a fixed repeating pattern.
	int rx_cycle = 0;

	always @(negedge clk) begin
		logic rdy;
		rx_cycle++;
		case ((rx_cycle / 64) % 4)
			0: rdy = 1'b1;
			1: rdy = 1'($urandom_range(0, 1));
			2: rdy = ($urandom_range(0, 3) == 0);
			default: rdy = (rx_cycle % 3) != 0;
		endcase
		out_if.ready <= arst_n && !hold_off && rdy;
	end

	// Long receiver hold-off so the block backs up into its input.
	initial begin
		wait (units_in >= 120);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin : mon
		utf8_byte_t want;
		if (!arst_n) begin
			in_fire = 1'b0;
		end else begin
			in_fire = in_if.valid && in_if.ready;
			if (in_fire) begin
				encode_unit(in_if.code_unit, in_if.final_unit);
				units_in++;
			end
			if (out_if.valid && out_if.ready) begin
				bytes_out++;
				if (utf8_q.size() == 0) begin
					report_mismatch($sformatf("byte %02h last=%0b with nothing expected",
						out_if.out_byte, out_if.run_last));
				end else begin
					want = utf8_q.pop_front();
					if (out_if.out_byte !== want.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_if.out_byte, want.data));
					if (out_if.run_last !== want.last)
						report_mismatch($sformatf("run_last %0b, expected %0b on byte %02h",
							out_if.run_last, want.last, want.data));
				end
			end
		end
	end

	initial begin
		int waited;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		while (unit_q.size() != 0 || in_if.valid)
			@(posedge clk);
		waited = 0;
		while (utf8_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (utf8_q.size() != 0)
			report_mismatch($sformatf("%0d expected bytes never arrived", utf8_q.size()));
		$display("covered %0d code units over %0d random strings plus directed corners",
			units_in, strings_sent);
		$display("checked %0d UTF-8 bytes, %0d of them from four-byte characters",
			bytes_out, four_byte_chars * 4);
		if (err_count == 0)
			$display("tb_utf16_to_utf8_encoder_top: clean");
		else
			$display("tb_utf16_to_utf8_encoder_top: errors");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("timeout: run did not complete");
		$display("tb_utf16_to_utf8_encoder_top: errors");
		$finish;
	end

endmodule
